// ----- design/emap_pkg.sv -----
`timescale 1ns / 1ps

package emap_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] cfg_index_t;

  // Item kinds.
  localparam kind_t KIND_XLATE = 2'd0;
  localparam kind_t KIND_GROW = 2'd1;
  localparam kind_t KIND_FORMAT = 2'd2;

  // Result status codes.
  localparam status_t ST_OK = 3'd0;
  localparam status_t ST_NEG = 3'd1;
  localparam status_t ST_BEYOND = 3'd2;
  localparam status_t ST_NOROOM = 3'd3;
  localparam status_t ST_OVF = 3'd4;

  // Configuration register indexes.
  localparam cfg_index_t CFG_B_PAGES = 2'd0;
  localparam cfg_index_t CFG_D_PAGES = 2'd1;
  localparam cfg_index_t CFG_SLOT_CAP = 2'd2;

  localparam logic [31:0] MARK = 32'hFFFF_FFFF;
  localparam logic [6:0] SLOT_CAP_RESET = 7'd64;
  localparam int LAYOUT_SLOTS = 5;

endpackage

// ----- design/extent_map_page_translator.sv -----
`timescale 1ns / 1ps

// Sequence: for an unused kind or a negative page, done pulses in the cycle after start.
// Format writes the layout slot by slot, a translate walks the extent pairs that it visits,
// and a grow walks the extents of its table. The extent list sits in one
// single-port-read memory, so the walks take one slot read per cycle.
// Throughput: one item at a time; start is taken whenever busy is low, even in the done cycle.
// Reset (rst, synchronous) writes the initial layout with busy high and no done pulse.
module extent_map_page_translator #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  emap_pkg::kind_t      kind,
  input  logic                 table_d,
  input  logic signed [31:0]   rel_page,
  input  logic [29:0]          amount,
  output logic                 done,
  output logic [30:0]          abs_page,
  output emap_pkg::status_t    status,
  output logic [30:0]          b_pages_total,
  output logic [30:0]          d_pages_total,
  input  logic                 cfg_we,
  input  emap_pkg::cfg_index_t cfg_index,
  input  logic [29:0]          cfg_wdata
);

  localparam int AB = $clog2(MAX_SLOTS);
  localparam int IW = AB + 1;
  localparam int AW = AB + 34;
  localparam int CW = (IW > 7) ? IW : 7;
  localparam logic [IW-1:0] MAXI = IW'(MAX_SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FMT = 3'd1;
  localparam logic [2:0] S_TX = 3'd2;
  localparam logic [2:0] S_TY = 3'd3;
  localparam logic [2:0] S_GW = 3'd4;
  localparam logic [2:0] S_GE = 3'd5;
  localparam logic [2:0] S_GA = 3'd6;

  logic [31:0] mem [MAX_SLOTS];
  logic [31:0] rdata;
  logic [AB-1:0] raddr;
  logic [AB-1:0] waddr;
  logic [31:0] wdata;
  logic we;

  logic [29:0] init_b;
  logic [29:0] init_d;
  logic [6:0] slot_cap;

  logic [2:0] state, state_next;
  logic init_fmt, init_fmt_next;
  logic [2:0] fi, fi_next;
  logic k_tab, k_tab_next;
  logic signed [31:0] k_rel, k_rel_next;
  logic [29:0] k_amt, k_amt_next;
  logic [IW-1:0] ix, ix_next;
  logic signed [AW-1:0] other, other_next;
  logic [30:0] ybase, ybase_next;
  logic first, first_next;
  logic [30:0] lastv, lastv_next;
  logic found, found_next;
  logic [30:0] endv, endv_next;
  logic [IW-1:0] slots_used, slots_used_next;
  logic [30:0] b_size, b_size_next;
  logic [30:0] d_size, d_size_next;
  logic done_next;
  emap_pkg::status_t status_next;
  logic [30:0] abs_page_next;

  logic [IW-1:0] ix_p1, ix_p2, ix_m1;
  logic [30:0] rd_val;
  logic [29:0] fb, fd;
  logic [30:0] fmt_b1, fmt_bd1;
  logic [30:0] tot;
  logic [31:0] tot_sum, ext_sum, app_sum;
  logic signed [AW-1:0] rel_ext, rd_ext, yb_ext, tr_sum;
  logic [CW-1:0] cap_w;
  logic room_fail;

  // An entry counts only below the fill mark and when it is not an end marker.
  function automatic logic slot_ok(input logic [IW-1:0] idx, input logic [IW-1:0] used,
                                   input logic [31:0] word);
    return (idx < used) && (idx < MAXI) && (word != emap_pkg::MARK);
  endfunction

  assign busy = (state != S_IDLE);
  assign b_pages_total = b_size;
  assign d_pages_total = d_size;

  assign ix_p1 = ix + IW'(1);
  assign ix_p2 = ix + IW'(2);
  assign ix_m1 = ix - IW'(1);
  assign rd_val = rdata[30:0];
  assign fb = init_fmt ? 30'd0 : init_b;
  assign fd = init_fmt ? 30'd0 : init_d;
  assign fmt_b1 = {1'b0, fb} + 31'd1;
  assign fmt_bd1 = {1'b0, fb} + {1'b0, fd} + 31'd1;
  assign tot = k_tab ? d_size : b_size;
  assign tot_sum = {1'b0, tot} + {2'b00, k_amt};
  assign ext_sum = {1'b0, rd_val} + {2'b00, k_amt};
  assign app_sum = {1'b0, lastv} + {2'b00, k_amt};
  assign rel_ext = AW'(k_rel);
  assign rd_ext = $signed({{(AW-31){1'b0}}, rd_val});
  assign yb_ext = $signed({{(AW-31){1'b0}}, ybase});
  assign tr_sum = rel_ext + other;
  assign cap_w = (CW'(slot_cap) < CW'(MAX_SLOTS)) ? CW'(slot_cap) : CW'(MAX_SLOTS);
  assign room_fail = (CW'(slots_used) >= cap_w) || (CW'(ix_p1) >= cap_w);

  always_comb begin
    state_next = state;
    init_fmt_next = init_fmt;
    fi_next = fi;
    k_tab_next = k_tab;
    k_rel_next = k_rel;
    k_amt_next = k_amt;
    ix_next = ix;
    other_next = other;
    ybase_next = ybase;
    first_next = first;
    lastv_next = lastv;
    found_next = found;
    endv_next = endv;
    slots_used_next = slots_used;
    b_size_next = b_size;
    d_size_next = d_size;
    done_next = 1'b0;
    status_next = status;
    abs_page_next = abs_page;
    raddr = ix[AB-1:0];
    we = 1'b0;
    waddr = ix[AB-1:0];
    wdata = emap_pkg::MARK;

    case (state)
      S_IDLE: begin
        if (start) begin
          k_tab_next = table_d;
          k_rel_next = rel_page;
          k_amt_next = amount;
          ix_next = IW'(table_d);
          raddr = AB'(table_d);
          case (kind)
            emap_pkg::KIND_XLATE: begin
              if (rel_page[31]) begin
                state_next = S_IDLE;
                done_next = 1'b1;
                status_next = emap_pkg::ST_NEG;
                abs_page_next = '0;
              end else begin
                first_next = 1'b1;
                state_next = S_TX;
              end
            end
            emap_pkg::KIND_GROW: begin
              found_next = 1'b0;
              state_next = S_GW;
            end
            emap_pkg::KIND_FORMAT: begin
              fi_next = '0;
              state_next = S_FMT;
            end
            default: begin
              done_next = 1'b1;
              status_next = emap_pkg::ST_OK;
              abs_page_next = '0;
            end
          endcase
        end
      end

      S_FMT: begin
        we = 1'b1;
        waddr = AB'(fi);
        case (fi)
          3'd0: wdata = 32'd1;
          3'd1: wdata = {1'b0, fmt_b1};
          3'd2: wdata = {1'b0, fmt_bd1};
          default: wdata = emap_pkg::MARK;
        endcase
        if (fi == 3'(emap_pkg::LAYOUT_SLOTS - 1)) begin
          slots_used_next = IW'(emap_pkg::LAYOUT_SLOTS);
          b_size_next = {1'b0, fb};
          d_size_next = {1'b0, fd};
          init_fmt_next = 1'b0;
          state_next = S_IDLE;
          done_next = !init_fmt;
          status_next = emap_pkg::ST_OK;
          abs_page_next = '0;
        end else begin
          fi_next = fi + 3'd1;
        end
      end

      S_TX: begin
        if (!slot_ok(ix, slots_used, rdata)) begin
          state_next = S_IDLE;
          done_next = 1'b1;
          status_next = emap_pkg::ST_BEYOND;
          abs_page_next = '0;
        end else begin
          // Pages of the other table between this extent and the table's start.
          other_next = first ? rd_ext : other + rd_ext - yb_ext;
          first_next = 1'b0;
          raddr = ix_p1[AB-1:0];
          state_next = S_TY;
        end
      end

      S_TY: begin
        if (!slot_ok(ix_p1, slots_used, rdata)) begin
          state_next = S_IDLE;
          done_next = 1'b1;
          status_next = emap_pkg::ST_BEYOND;
          abs_page_next = '0;
        end else if (tr_sum < rd_ext) begin
          state_next = S_IDLE;
          done_next = 1'b1;
          status_next = emap_pkg::ST_OK;
          abs_page_next = tr_sum[30:0];
        end else begin
          ybase_next = rd_val;
          ix_next = ix_p2;
          raddr = ix_p2[AB-1:0];
          state_next = S_TX;
        end
      end

      S_GW: begin
        if (slot_ok(ix, slots_used, rdata)) begin
          lastv_next = rd_val;
          found_next = 1'b1;
          ix_next = ix_p2;
          raddr = ix_p2[AB-1:0];
        end else if (!found) begin
          state_next = S_IDLE;
          done_next = 1'b1;
          status_next = emap_pkg::ST_BEYOND;
          abs_page_next = '0;
        end else begin
          // The entry after the last extent start holds its end, or a marker.
          raddr = ix_m1[AB-1:0];
          state_next = S_GE;
        end
      end

      S_GE: begin
        state_next = S_IDLE;
        done_next = 1'b1;
        abs_page_next = '0;
        if (tot_sum[31]) begin
          status_next = emap_pkg::ST_OVF;
        end else if (slot_ok(ix_m1, slots_used, rdata)) begin
          if (ext_sum[31]) begin
            status_next = emap_pkg::ST_OVF;
          end else begin
            we = 1'b1;
            waddr = ix_m1[AB-1:0];
            wdata = {1'b0, ext_sum[30:0]};
            status_next = emap_pkg::ST_OK;
            if (k_tab) begin
              d_size_next = tot_sum[30:0];
            end else begin
              b_size_next = tot_sum[30:0];
            end
          end
        end else if (room_fail) begin
          status_next = emap_pkg::ST_NOROOM;
        end else if (app_sum[31]) begin
          status_next = emap_pkg::ST_OVF;
        end else begin
          endv_next = app_sum[30:0];
          fi_next = '0;
          done_next = 1'b0;
          state_next = S_GA;
        end
      end

      S_GA: begin
        we = 1'b1;
        fi_next = fi + 3'd1;
        case (fi)
          3'd0: begin
            waddr = ix_m1[AB-1:0];
            wdata = {1'b0, endv};
          end
          3'd1: begin
            waddr = ix[AB-1:0];
          end
          default: begin
            waddr = ix_p1[AB-1:0];
            slots_used_next = ix_p2;
            if (k_tab) begin
              d_size_next = tot_sum[30:0];
            end else begin
              b_size_next = tot_sum[30:0];
            end
            state_next = S_IDLE;
            done_next = 1'b1;
            status_next = emap_pkg::ST_OK;
            abs_page_next = '0;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_b <= '0;
      init_d <= '0;
      slot_cap <= emap_pkg::SLOT_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        emap_pkg::CFG_B_PAGES: init_b <= cfg_wdata;
        emap_pkg::CFG_D_PAGES: init_d <= cfg_wdata;
        emap_pkg::CFG_SLOT_CAP: slot_cap <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FMT;
      init_fmt <= 1'b1;
      fi <= '0;
      slots_used <= IW'(emap_pkg::LAYOUT_SLOTS);
      b_size <= '0;
      d_size <= '0;
      done <= 1'b0;
      status <= emap_pkg::ST_OK;
      abs_page <= '0;
    end else begin
      state <= state_next;
      init_fmt <= init_fmt_next;
      fi <= fi_next;
      slots_used <= slots_used_next;
      b_size <= b_size_next;
      d_size <= d_size_next;
      done <= done_next;
      status <= status_next;
      abs_page <= abs_page_next;
    end
  end

  always_ff @(posedge clk) begin
    k_tab <= k_tab_next;
    k_rel <= k_rel_next;
    k_amt <= k_amt_next;
    ix <= ix_next;
    other <= other_next;
    ybase <= ybase_next;
    first <= first_next;
    lastv <= lastv_next;
    found <= found_next;
    endv <= endv_next;
  end

endmodule

// ----- design/emap_chk.sv -----
`timescale 1ns / 1ps

module emap_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [30:0]       abs_page,
  input emap_pkg::status_t status,
  input logic [30:0]       b_pages_total,
  input logic [30:0]       d_pages_total
);

  // A result is shown only once the block has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // An accepted item either finishes at once or keeps the block busy.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither busy nor done");

  // Only a successful translate reports a page.
  a_abs_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != emap_pkg::ST_OK) |-> (abs_page == 31'd0))
    else $error("page reported with a failing status");

  // The size totals move only together with a result.
  a_totals: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !done) |-> ($stable(b_pages_total) && $stable(d_pages_total)))
    else $error("size totals changed without a result");

endmodule

bind extent_map_page_translator emap_chk u_emap_chk (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .abs_page(abs_page),
  .status(status),
  .b_pages_total(b_pages_total),
  .d_pages_total(d_pages_total)
);
